[sv/assert_macros.svh]
// Assertion helpers for the cache simulator checks.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SALRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define SALRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/salru_pkg.sv]
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types, codes and sizing constants of the LRU cache simulator.
// ----------------------------------------------------------------------------
package salru_pkg;

  // Address and tag sizing
  localparam int ADDR_W = 32;
  localparam int TAG_W  = ADDR_W - 2;

  // Default geometry of the line store
  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  // Access kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  // Access outcomes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]        access_kind;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
    logic last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic modify;
    logic out_free;
  } sts_t;

endpackage

[sv/salru_ctrl.sv]
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer: capture a transaction, then read and update the set once per
// access (twice for modify), stalling while the result register is full.
// ----------------------------------------------------------------------------
module salru_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  salru_pkg::sts_t sts_i,
  output salru_pkg::cmd_t cmd_o
);
  import salru_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0] state_q, state_d;
  logic       second_q, second_d;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          second_d      = 1'b0;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          cmd_o.last   = !(sts_i.modify && !second_q);
          if (sts_i.modify && !second_q) begin
            second_d = 1'b1;
            state_d  = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

endmodule

[sv/salru_dpath.sv]
// ----------------------------------------------------------------------------
// salru_dpath
// Address split, set row memory, tag lookup, LRU update, totals and the
// result register.
// ----------------------------------------------------------------------------
module salru_dpath #(
  parameter int MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  salru_pkg::in_item_t                  in_data_i,
  output salru_pkg::out_item_t                 out_data_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  salru_pkg::cmd_t                      cmd_i,
  output salru_pkg::sts_t                      sts_o
);
  import salru_pkg::*;

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  // Way counts up to sixteen fit in five bits
  localparam int WCNT_W = 5;

  // Configuration registers
  logic [2:0] set_bits_q;
  logic [4:0] off_bits_q;
  logic [3:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd1;
      off_bits_q <= 5'd1;
      ways_q     <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_BITS: set_bits_q <= cfg_wdata_i[2:0];
        CFG_OFF_BITS: off_bits_q <= cfg_wdata_i[4:0];
        CFG_WAYS:     ways_q     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Split the address into set index and tag
  logic [ADDR_W-1:0] set_shift, tag_shift;
  logic [5:0]        tag_sh;
  logic [SET_W-1:0]  set_mask, set_in;

  always_comb begin
    set_shift = in_data_i.address >> off_bits_q;
    tag_sh    = {1'b0, off_bits_q} + {3'b000, set_bits_q};
    tag_shift = in_data_i.address >> tag_sh;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (int'(set_bits_q) > i);
    end
    set_in = set_shift[SET_W-1:0] & set_mask;
  end

  logic             modify_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  // Hold the captured access
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      modify_q <= (in_data_i.access_kind == KIND_MODIFY);
      set_q    <= set_in;
      tag_q    <= tag_shift[TAG_W-1:0];
    end
  end

  // Set row memory and per-row valid flags
  logic [MAX_WAYS-1:0]                  mem_vld [MAX_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0]      mem_age [MAX_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0]       mem_tag [MAX_SETS];
  logic [MAX_SETS-1:0]                  row_valid_q;

  logic                                 rd_row_q;
  logic [MAX_WAYS-1:0]                  rd_vld_q;
  logic [MAX_WAYS-1:0][RANK_W-1:0]      rd_age_q;
  logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tag_q;

  logic [MAX_WAYS-1:0]                  new_vld;
  logic [MAX_WAYS-1:0][RANK_W-1:0]      new_age;
  logic [MAX_WAYS-1:0][TAG_W-1:0]       new_tag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_vld[set_q] <= new_vld;
      mem_age[set_q] <= new_age;
      mem_tag[set_q] <= new_tag;
    end
    if (cmd_i.rd_en) begin
      rd_vld_q <= mem_vld[set_q];
      rd_age_q <= mem_age[set_q];
      rd_tag_q <= mem_tag[set_q];
    end
  end

  // A row never written reads as empty with zero ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_row_q    <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        row_valid_q[set_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_row_q <= row_valid_q[set_q];
      end
    end
  end

  // Lookup, victim choice and LRU update
  logic [WCNT_W-1:0]               act_ways;
  logic [MAX_WAYS-1:0]             act;
  logic [MAX_WAYS-1:0]             cur_vld;
  logic [MAX_WAYS-1:0][RANK_W-1:0] cur_age;
  logic                            hit, has_empty;
  logic [WAY_W-1:0]                hit_way, empty_way, victim_way, pick;
  logic [RANK_W-1:0]               hit_age, victim_age;
  logic [1:0]                      outcome;

  always_comb begin
    act_ways = {1'b0, ways_q};
    if (act_ways == '0) begin
      act_ways = WCNT_W'(1);
    end else if (act_ways > WCNT_W'(MAX_WAYS)) begin
      act_ways = WCNT_W'(MAX_WAYS);
    end

    cur_vld = rd_row_q ? rd_vld_q : '0;
    cur_age = rd_row_q ? rd_age_q : '0;

    hit       = 1'b0;
    hit_way   = '0;
    has_empty = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      act[w] = (WCNT_W'(w) < act_ways);
      if (act[w] && cur_vld[w] && (rd_tag_q[w] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (act[w] && !cur_vld[w]) begin
        has_empty = 1'b1;
        empty_way = WAY_W'(w);
      end
    end

    // Oldest way in use, lowest index on a tie
    victim_way = '0;
    victim_age = cur_age[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (act[w] && (cur_age[w] > victim_age)) begin
        victim_way = WAY_W'(w);
        victim_age = cur_age[w];
      end
    end

    hit_age = cur_age[hit_way];

    priority if (hit) begin
      pick    = hit_way;
      outcome = OUT_HIT;
    end else if (has_empty) begin
      pick    = empty_way;
      outcome = OUT_FILL;
    end else begin
      pick    = victim_way;
      outcome = OUT_EVICT;
    end

    new_vld = cur_vld;
    new_tag = rd_tag_q;
    new_age = cur_age;
    if (!hit) begin
      new_vld[pick] = 1'b1;
      new_tag[pick] = tag_q;
    end
    // Age the younger valid ways, then make the picked way most recent
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (act[w] && (WAY_W'(w) != pick) && cur_vld[w] &&
          (!hit || (cur_age[w] < hit_age)) && (cur_age[w] < RANK_MAX)) begin
        new_age[w] = cur_age[w] + RANK_W'(1);
      end
    end
    new_age[pick] = '0;
  end

  // Saturating totals
  logic [31:0] hits_q, misses_q, evicts_q;
  logic [31:0] hits_d, misses_d, evicts_d;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (outcome == OUT_HIT) begin
      if (hits_q != COUNT_MAX) hits_d = hits_q + 32'd1;
    end else begin
      if (misses_q != COUNT_MAX) misses_d = misses_q + 32'd1;
      if ((outcome == OUT_EVICT) && (evicts_q != COUNT_MAX)) evicts_d = evicts_q + 32'd1;
    end
  end

  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.outcome        <= outcome;
      out_q.hit_total      <= hits_d;
      out_q.miss_total     <= misses_d;
      out_q.eviction_total <= evicts_d;
      out_q.last           <= cmd_i.last;
    end
  end

  assign out_data_o      = out_q;
  assign out_valid_o     = out_valid_q;
  assign sts_o.modify    = modify_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[sv/set_assoc_cache_lru_sim_unit.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_unit
// Set-associative cache simulator with true LRU and saturating totals.
// ----------------------------------------------------------------------------
// A transaction is captured, its set row read in ST_READ, and the result
// registered as ST_EVAL writes the row back (twice for a modify, two results);
// only then is a new one taken. Each access is one registered read and one
// writeback of the set row memory. A full result register stalls the writeback
// until the result is taken. Reset: totals and per-set valid flags clear
// at once (no clearing pass); all three configuration registers reset to 1.
module set_assoc_cache_lru_sim_unit #(
  parameter int MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  salru_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output salru_pkg::out_item_t             out_data_o
);
  import salru_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  salru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Lookup and update datapath
  salru_dpath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[sv/salru_checker.sv]
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks of the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salru_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input salru_pkg::out_item_t out_data_o
);
  import salru_pkg::*;

  // Handshake and result conditions seen on the ports
  logic in_take;
  logic out_stall;
  logic res_hit;
  logic res_miss;
  logic hit_total_ok;
  logic miss_totals_ok;

  assign in_take        = in_valid_i && in_ready_o;
  assign out_stall      = out_valid_o && !out_ready_i;
  assign res_hit        = out_valid_o && (out_data_o.outcome == OUT_HIT);
  assign res_miss       = out_valid_o && (out_data_o.outcome != OUT_HIT);
  assign hit_total_ok   = (out_data_o.hit_total != 32'd0);
  assign miss_totals_ok = (out_data_o.miss_total != 32'd0) &&
                          ((out_data_o.outcome != OUT_EVICT) ||
                           (out_data_o.eviction_total != 32'd0));

  // Hold a stalled result: keep it valid and unchanged
  `SALRU_ASSERT_NXT(a_out_keep, clk_i, rst_ni, out_stall, out_valid_o, "result dropped")
  `SALRU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_data_o), "result changed")

  // Drop ready while a transaction is in progress
  `SALRU_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_take, !in_ready_o, "taken while busy")

  // A hit result carries a nonzero hit total
  `SALRU_ASSERT_IMP(a_hit_total, clk_i, rst_ni, res_hit, hit_total_ok, "hit with zero hit total")

  // A miss result carries nonzero miss and, on eviction, eviction totals
  `SALRU_ASSERT_IMP(a_miss_total, clk_i, rst_ni, res_miss, miss_totals_ok, "miss with bad totals")

endmodule

bind set_assoc_cache_lru_sim_unit salru_checker u_salru_checker (.*);
